// ----- rtl/gha_pkg.sv -----
package gha_pkg;

	// slot count and derived widths
	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int GEN_W  = 16;
	localparam int HIDX_W = 16;
	localparam int TAG_W  = GEN_W + 1;
	localparam int SIDX_W = 6;

	// stream widths, padded to whole bytes
	localparam int IN_W  = 40;
	localparam int OUT_W = 40;

	// command codes
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;

	// sequencer state codes
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

endpackage

// ----- rtl/generational_handle_allocator.sv -----
// Generation-tagged handle allocator for up to SLOTS slots.
// Input stream s_axis carries one command per beat: create, destroy or lookup,
// with a 32-bit handle (generation in bits 31..16, slot index in bits 15..0).
// Output stream m_axis returns exactly one result beat per command: ok flag,
// the new handle on a successful create, and the slot index.
// A command and both memory reads are registered on accept; the command then
// executes and its result is registered in the output register. The slot tag
// table and the free stack are synchronous-read memories; a command reads both in
// its accept cycle and writes them back when it completes execution, and the next
// command is taken only after that write.
// Reset (arst_n low): every slot free with generation 0, free stack holds all
// slots with slot 0 on top, current generation is 1. Per-entry valid bits
// stand in for the reset contents, so no clearing pass is needed and the
// block accepts commands in the first cycle after reset.
// A stalled receiver holds the result in the output register; one more
// command may be accepted and read meanwhile, and it waits in the execute
// cycle until the output register frees.
module generational_handle_allocator
	import gha_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // cmd[1:0], handle_in[33:2], zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // ok[0], handle_out[32:1], slot_index[38:33], pad
);

	localparam logic [HIDX_W:0] SLOTS_L   = (HIDX_W + 1)'(SLOTS);
	localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// memories and their valid bits
	logic [TAG_W-1:0] tag_mem [SLOTS];
	logic [IDX_W-1:0] fl_mem  [SLOTS];
	logic [SLOTS-1:0] tag_vld_q;
	logic [SLOTS-1:0] fl_vld_q;

	// control state
	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [GEN_W-1:0] gen_q;
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	// stage one registers
	logic [1:0]       cmd_s1;
	logic [31:0]      handle_s1;
	logic [TAG_W-1:0] tag_rd_s1;
	logic             tag_vld_s1;
	logic [IDX_W-1:0] fl_rd_s1;
	logic             fl_vld_s1;
	logic [IDX_W-1:0] fl_addr_s1;

	// input decode
	logic             accept;
	logic [1:0]       in_cmd;
	logic [31:0]      in_handle;
	logic [IDX_W-1:0] tag_rd_addr;
	logic [IDX_W-1:0] fl_rd_addr;

	// execute logic
	logic             complete;
	logic [HIDX_W-1:0] hidx;
	logic             found;
	logic [IDX_W-1:0] fl_val;
	logic             tag_we;
	logic [IDX_W-1:0] tag_wa;
	logic [TAG_W-1:0] tag_wd;
	logic             fl_we;
	logic [IDX_W-1:0] fl_wa;
	logic [CNT_W-1:0] cnt_d;
	logic [GEN_W-1:0] gen_d;
	logic             res_ok;
	logic [31:0]      res_handle;
	logic [IDX_W-1:0] res_slot;

	assign in_cmd      = s_axis_tdata[1:0];
	assign in_handle   = s_axis_tdata[33:2];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign tag_rd_addr = in_handle[IDX_W-1:0];
	assign fl_rd_addr  = IDX_W'(cnt_q - 1'b1);
	assign complete    = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (complete) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture command and read both memories on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= in_cmd;
			handle_s1  <= in_handle;
			tag_rd_s1  <= tag_mem[tag_rd_addr];
			tag_vld_s1 <= tag_vld_q[tag_rd_addr];
			fl_rd_s1   <= fl_mem[fl_rd_addr];
			fl_vld_s1  <= fl_vld_q[fl_rd_addr];
			fl_addr_s1 <= fl_rd_addr;
		end
	end

	// handle check and stack top
	always_comb begin
		hidx   = handle_s1[HIDX_W-1:0];
		found  = (handle_s1 != 32'd0) && ({1'b0, hidx} < SLOTS_L) && tag_vld_s1
			&& tag_rd_s1[GEN_W] && (tag_rd_s1[GEN_W-1:0] == handle_s1[31:16]);
		fl_val = fl_vld_s1 ? fl_rd_s1 : (LAST_IDX - fl_addr_s1);
	end

	// command execution
	always_comb begin
		tag_we     = 1'b0;
		tag_wa     = fl_val;
		tag_wd     = {1'b1, gen_q};
		fl_we      = 1'b0;
		fl_wa      = cnt_q[IDX_W-1:0];
		cnt_d      = cnt_q;
		gen_d      = gen_q;
		res_ok     = 1'b0;
		res_handle = 32'd0;
		res_slot   = '0;
		case (cmd_s1)
			CMD_CREATE: begin
				if (cnt_q != '0) begin
					tag_we     = 1'b1;
					cnt_d      = cnt_q - 1'b1;
					res_ok     = 1'b1;
					res_handle = {gen_q, HIDX_W'(fl_val)};
					res_slot   = fl_val;
				end
			end
			CMD_DESTROY: begin
				if (found) begin
					tag_we = 1'b1;
					tag_wa = hidx[IDX_W-1:0];
					tag_wd = '0;
					if (cnt_q < SLOTS_C) begin
						fl_we = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
					if (tag_rd_s1[GEN_W-1:0] >= gen_q) gen_d = gen_q + 1'b1;
					res_ok   = 1'b1;
					res_slot = hidx[IDX_W-1:0];
				end
			end
			CMD_LOOKUP: begin
				if (found) begin
					res_ok   = 1'b1;
					res_slot = hidx[IDX_W-1:0];
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (complete && tag_we) tag_mem[tag_wa] <= tag_wd;
		if (complete && fl_we) fl_mem[fl_wa] <= tag_wa;
	end

	// valid bits, count and generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_q <= '0;
			fl_vld_q  <= '0;
			cnt_q     <= SLOTS_C;
			gen_q     <= GEN_W'(1);
		end else if (complete) begin
			if (tag_we) tag_vld_q[tag_wa] <= 1'b1;
			if (fl_we) fl_vld_q[fl_wa] <= 1'b1;
			cnt_q <= cnt_d;
			gen_q <= gen_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (complete) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			m_data_q <= {1'b0, SIDX_W'(res_slot), res_handle, res_ok};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
	// free count stays within the slot count
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOTS_C)
		else $error("free count above slot count");

	// failed results carry no handle and no slot
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[38:1] == 38'd0))
		else $error("failed result with nonzero payload");

	// a result is never overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result overwritten");

	// generation only moves on a completed destroy
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(complete && cmd_s1 == CMD_DESTROY) |=> $stable(gen_q))
		else $error("generation changed without destroy");
`endif

endmodule
